FILE: src/r2fft_pkg.sv
package r2fft_pkg;

   localparam int INDEX_BITS = 11;
   localparam int MODE_BITS  = 2;

   localparam logic [MODE_BITS-1:0] MODE_LOAD = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_RUN  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_READ = 2'd2;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_BIN  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_OUT,
      ST_BR_RD,
      ST_BR_WA,
      ST_BR_WB,
      ST_BF_RD,
      ST_BF_MUL,
      ST_BF_SUM,
      ST_BF_WA,
      ST_BF_WB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } bf_ctrl_type;

endpackage

FILE: src/r2fft_bfly.sv
module r2fft_bfly #(
   parameter int WORD_BITS    = 28,
   parameter int TWIDDLE_BITS = 18
) (
   input  logic                           clock,
   input  r2fft_pkg::bf_ctrl_type         ctrl,
   input  logic signed [WORD_BITS-1:0]    a_re,
   input  logic signed [WORD_BITS-1:0]    a_im,
   input  logic signed [WORD_BITS-1:0]    b_re,
   input  logic signed [WORD_BITS-1:0]    b_im,
   input  logic signed [TWIDDLE_BITS-1:0] w_re,
   input  logic signed [TWIDDLE_BITS-1:0] w_im,
   output logic signed [WORD_BITS-1:0]    sum_re,
   output logic signed [WORD_BITS-1:0]    sum_im,
   output logic signed [WORD_BITS-1:0]    dif_re,
   output logic signed [WORD_BITS-1:0]    dif_im
);
   import r2fft_pkg::*;

   localparam int PW   = WORD_BITS + TWIDDLE_BITS;
   localparam int FRAC = TWIDDLE_BITS - 1;
   localparam logic signed [PW:0] RND = (PW+1)'(1) <<< (FRAC - 1);

   logic signed [PW-1:0]        m_rr_ff, m_ii_ff, m_ri_ff, m_ir_ff;
   logic signed [PW:0]          t_re, t_im;
   logic signed [WORD_BITS-1:0] p_re_ff, p_im_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         m_rr_ff <= b_re * w_re;
         m_ii_ff <= b_im * w_im;
         m_ri_ff <= b_re * w_im;
         m_ir_ff <= b_im * w_re;
      end
   end

   // round to nearest, ties upward
   always_comb begin
      t_re = (PW+1)'(m_rr_ff) - (PW+1)'(m_ii_ff) + RND;
      t_im = (PW+1)'(m_ri_ff) + (PW+1)'(m_ir_ff) + RND;
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         p_re_ff <= WORD_BITS'(t_re >>> FRAC);
         p_im_ff <= WORD_BITS'(t_im >>> FRAC);
      end
   end

   assign sum_re = a_re + p_re_ff;
   assign sum_im = a_im + p_im_ff;
   assign dif_re = a_re - p_re_ff;
   assign dif_im = a_im - p_im_ff;

endmodule

FILE: src/radix2_fft_engine.sv
// Channel   Ports                                           Direction
// request   start, busy, req_mode, req_index, req_sample_*  in (busy out)
// response  rsp_valid, rsp_kind, rsp_bin_index, rsp_bin_*   out
//
// Load: busy stays low. Read: data strobed in the cycle after the request.
// Run: a bit-reverse pass (read, write both words of a swapped pair), then one
// butterfly at a time per stage (read, multiply, sum, write A, write B), then the
// done strobe; the one butterfly unit and the single write port of the work store serialize it.
// Reset is synchronous and clears the sequencer only; the store is undefined.
// The receiver cannot stall: each response is strobed for exactly one cycle.
module radix2_fft_engine #(
   parameter int POINTS       = 2048,
   parameter int SAMPLE_BITS  = 16,
   parameter int WORD_BITS    = 28,
   parameter int TWIDDLE_BITS = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [r2fft_pkg::MODE_BITS-1:0]     req_mode,
   input  logic [r2fft_pkg::INDEX_BITS-1:0]    req_index,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_real,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_imag,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic [r2fft_pkg::INDEX_BITS-1:0]    rsp_bin_index,
   output logic signed [WORD_BITS-1:0]         rsp_bin_real,
   output logic signed [WORD_BITS-1:0]         rsp_bin_imag
);
   import r2fft_pkg::*;

   localparam int LOG  = $clog2(POINTS);
   localparam int SB   = $clog2(LOG);
   localparam int TF   = TWIDDLE_BITS - 1;
   localparam int DW   = 2 * WORD_BITS;
   localparam int TWW  = 2 * TWIDDLE_BITS;
   localparam logic [LOG-1:0]   LAST_I = {LOG{1'b1}};
   localparam logic [LOG-2:0]   LAST_M = {(LOG-1){1'b1}};
   localparam logic [SB-1:0]    LAST_S = SB'(LOG - 1);

   // twiddle table built at elaboration
   function automatic logic [63:0] mq(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] t;
      t = a * b + 64'd536870912;
      return t >> 30;
   endfunction

   function automatic logic [TWIDDLE_BITS-1:0] quant(input logic signed [63:0] v);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] lim;
      neg = v < 0;
      mag = neg ? 64'(-v) : 64'(v);
      lim = (64'd1 << TF) - 64'd1;
      mag = (mag + (64'd1 << (29 - TF))) >> (30 - TF);
      if (mag > lim) mag = lim;
      return TWIDDLE_BITS'(neg ? (64'd0 - mag) : mag);
   endfunction

   function automatic logic [TWW-1:0] tw_entry(input int unsigned kk);
      logic               up;
      logic [63:0]        j, x, x2, tc, ts;
      logic signed [63:0] sc, ss;
      up = kk > POINTS / 4;
      j  = up ? 64'(POINTS / 2 - kk) : 64'(kk);
      x  = j * 64'd6746518852 / POINTS;
      x2 = mq(x, x);
      tc = 64'd1073741824;
      ts = x;
      sc = 64'sd1073741824;
      ss = $signed(x);
      for (int n = 1; n <= 12; n++) begin
         tc = mq(tc, x2) / 64'((2 * n - 1) * (2 * n));
         ts = mq(ts, x2) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sc = sc - $signed(tc);
            ss = ss - $signed(ts);
         end else begin
            sc = sc + $signed(tc);
            ss = ss + $signed(ts);
         end
      end
      return {(up ? quant(-sc) : quant(sc)), quant(-ss)};
   endfunction

   logic [TWW-1:0] tw_rom [POINTS/2];
   for (genvar g = 0; g < POINTS / 2; g++) begin : g_rom
      assign tw_rom[g] = tw_entry(g);
   end

   state_type state_ff, state_in;

   logic [LOG-1:0] i_ff, i_in;
   logic [LOG-2:0] m_ff, m_in;
   logic [SB-1:0]  s_ff, s_in;
   logic [LOG-1:0] addr_ff;

   logic [DW-1:0]  store [POINTS];
   logic [DW-1:0]  rd_a_ff, rd_b_ff;
   logic [TWW-1:0] tw_ff;

   logic           we, re, tre;
   logic [LOG-1:0] wa, ra, rb;
   logic [DW-1:0]  wd;
   logic [LOG-2:0] ta;

   logic [LOG-1:0] req_addr, rev_i, m_ext, half, kpart, bf_a, bf_b;
   logic [SB-1:0]  tsh;
   logic           accept;
   bf_ctrl_type    bf_ctrl;

   logic signed [WORD_BITS-1:0] sum_re, sum_im, dif_re, dif_im;

   assign accept   = start && !busy;
   assign req_addr = LOG'(req_index);

   always_comb begin
      for (int b = 0; b < LOG; b++) rev_i[b] = i_ff[LOG-1-b];
   end

   // butterfly addresses from butterfly count and stage
   always_comb begin
      m_ext = {1'b0, m_ff};
      half  = LOG'(1) << s_ff;
      kpart = m_ext & (half - LOG'(1));
      bf_a  = ((m_ext >> s_ff) << (s_ff + SB'(1))) | kpart;
      bf_b  = bf_a | half;
      tsh   = LAST_S - s_ff;
      ta    = (LOG-1)'(kpart << tsh);
   end

   always_ff @(posedge clock) begin
      if (we) store[wa] <= wd;
      if (re) begin
         rd_a_ff <= store[ra];
         rd_b_ff <= store[rb];
      end
      if (tre) tw_ff <= tw_rom[ta];
   end

   r2fft_bfly #(
      .WORD_BITS    (WORD_BITS),
      .TWIDDLE_BITS (TWIDDLE_BITS)
   ) u_bfly (
      .clock  (clock),
      .ctrl   (bf_ctrl),
      .a_re   (rd_a_ff[DW-1:WORD_BITS]),
      .a_im   (rd_a_ff[WORD_BITS-1:0]),
      .b_re   (rd_b_ff[DW-1:WORD_BITS]),
      .b_im   (rd_b_ff[WORD_BITS-1:0]),
      .w_re   (tw_ff[TWW-1:TWIDDLE_BITS]),
      .w_im   (tw_ff[TWIDDLE_BITS-1:0]),
      .sum_re (sum_re),
      .sum_im (sum_im),
      .dif_re (dif_re),
      .dif_im (dif_im)
   );

   // next state and counters
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      m_in     = m_ff;
      s_in     = s_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_READ) state_in = ST_RD_OUT;
            if (accept && req_mode == MODE_RUN) begin
               state_in = ST_BR_RD;
               i_in     = '0;
            end
         end
         ST_RD_OUT: state_in = ST_IDLE;
         ST_BR_RD: begin
            if (i_ff < rev_i) begin
               state_in = ST_BR_WA;
            end else if (i_ff == LAST_I) begin
               state_in = ST_BF_RD;
               m_in     = '0;
               s_in     = '0;
            end else begin
               i_in = i_ff + LOG'(1);
            end
         end
         ST_BR_WA: state_in = ST_BR_WB;
         ST_BR_WB: begin
            state_in = ST_BR_RD;
            i_in     = i_ff + LOG'(1);
         end
         ST_BF_RD:  state_in = ST_BF_MUL;
         ST_BF_MUL: state_in = ST_BF_SUM;
         ST_BF_SUM: state_in = ST_BF_WA;
         ST_BF_WA:  state_in = ST_BF_WB;
         ST_BF_WB: begin
            state_in = ST_BF_RD;
            m_in     = m_ff + (LOG-1)'(1);
            if (m_ff == LAST_M) begin
               if (s_ff == LAST_S) state_in = ST_DONE;
               else s_in = s_ff + SB'(1);
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and store control
   always_comb begin
      busy          = 1'b1;
      we            = 1'b0;
      wa            = i_ff;
      wd            = rd_b_ff;
      re            = 1'b0;
      ra            = i_ff;
      rb            = rev_i;
      tre           = 1'b0;
      bf_ctrl       = '0;
      rsp_valid     = 1'b0;
      rsp_kind      = KIND_DONE;
      rsp_bin_index = '0;
      rsp_bin_real  = '0;
      rsp_bin_imag  = '0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            ra   = req_addr;
            re   = start && req_mode == MODE_READ;
            we   = start && req_mode == MODE_LOAD;
            wa   = req_addr;
            wd   = {WORD_BITS'(req_sample_real), WORD_BITS'(req_sample_imag)};
         end
         ST_RD_OUT: begin
            rsp_valid     = 1'b1;
            rsp_kind      = KIND_BIN;
            rsp_bin_index = INDEX_BITS'(addr_ff);
            rsp_bin_real  = rd_a_ff[DW-1:WORD_BITS];
            rsp_bin_imag  = rd_a_ff[WORD_BITS-1:0];
         end
         ST_BR_RD: re = i_ff < rev_i;
         ST_BR_WA: begin
            we = 1'b1;
            wa = i_ff;
            wd = rd_b_ff;
         end
         ST_BR_WB: begin
            we = 1'b1;
            wa = rev_i;
            wd = rd_a_ff;
         end
         ST_BF_RD: begin
            re  = 1'b1;
            tre = 1'b1;
            ra  = bf_a;
            rb  = bf_b;
         end
         ST_BF_MUL: bf_ctrl.mul_en = 1'b1;
         ST_BF_SUM: bf_ctrl.sum_en = 1'b1;
         ST_BF_WA: begin
            we = 1'b1;
            wa = bf_a;
            wd = {sum_re, sum_im};
         end
         ST_BF_WB: begin
            we = 1'b1;
            wa = bf_b;
            wd = {dif_re, dif_im};
         end
         ST_DONE: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         m_ff     <= '0;
         s_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         m_ff     <= m_in;
         s_ff     <= s_in;
      end
   end

   // hold the read address for the response
   always_ff @(posedge clock) begin
      if (accept) addr_ff <= req_addr;
   end

`ifndef SYNTHESIS
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside a busy cycle");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_RUN) |=> busy)
      else $error("run request did not start the sequencer");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_LOAD) |=> !busy && !rsp_valid)
      else $error("load request produced a response");
`endif

endmodule

FILE: verif/tb_radix2_fft_engine.sv
`timescale 1ns / 100ps

module tb_radix2_fft_engine;
   import r2fft_pkg::*;

   localparam int POINTS     = 2048;
   localparam int LOG_POINTS = 11;
   localparam int WORD_BITS  = 28;
   localparam int TW_FRAC    = 17;
   localparam int STALL_LIMIT = 400000;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [MODE_BITS-1:0]  mode;
      logic [INDEX_BITS-1:0] index;
      logic signed [15:0]    sample_real;
      logic signed [15:0]    sample_imag;
   } fft_request_type;

   typedef struct {
      logic                        kind;
      logic [INDEX_BITS-1:0]       bin_index;
      logic signed [WORD_BITS-1:0] bin_real;
      logic signed [WORD_BITS-1:0] bin_imag;
   } fft_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [MODE_BITS-1:0]  req_mode = MODE_LOAD;
   logic [INDEX_BITS-1:0] req_index = '0;
   logic signed [15:0]    req_sample_real = '0;
   logic signed [15:0]    req_sample_imag = '0;
   logic rsp_valid;
   logic rsp_kind;
   logic [INDEX_BITS-1:0]       rsp_bin_index;
   logic signed [WORD_BITS-1:0] rsp_bin_real;
   logic signed [WORD_BITS-1:0] rsp_bin_imag;

   fft_request_type  pending_requests[$];
   fft_response_type expected_bins[$];
   fft_request_type  active_request;

   longint twiddle_re[POINTS/2];
   longint twiddle_im[POINTS/2];
   longint spectrum_re[POINTS];
   longint spectrum_im[POINTS];

   int idle_pct = 0;
   int idle_pct_list[4] = '{0, 64, 0, 10};
   int error_count = 0;
   int load_count = 0;
   int run_count = 0;
   int read_count = 0;
   int quiet_cycles = 0;

   radix2_fft_engine i_dut (
      .clock, .reset, .start, .busy, .req_mode, .req_index,
      .req_sample_real, .req_sample_imag, .rsp_valid, .rsp_kind,
      .rsp_bin_index, .rsp_bin_real, .rsp_bin_imag
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic longint quantize_twiddle(longint v);
      longint unsigned mag;
      mag = (v < 0) ? longint'(-v) : v;
      mag = (mag + (64'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC);
      if (mag > (64'd1 << TW_FRAC) - 1) mag = (64'd1 << TW_FRAC) - 1;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   // Taylor series in Q2.30, first quadrant, mirrored for the second
   task automatic build_twiddles();
      longint unsigned x, x2, tc, ts, j;
      longint sc, ss;
      bit upper;
      for (int k = 0; k < POINTS / 2; k++) begin
         upper = k > POINTS / 4;
         j = upper ? 64'(POINTS / 2 - k) : 64'(k);
         x = j * 64'd6746518852 / POINTS;
         x2 = mul_q30(x, x);
         tc = 64'd1 << 30;
         ts = x;
         sc = 64'd1 << 30;
         ss = x;
         for (int n = 1; n <= 12; n++) begin
            tc = mul_q30(tc, x2) / ((2 * n - 1) * (2 * n));
            ts = mul_q30(ts, x2) / ((2 * n) * (2 * n + 1));
            if (n % 2) begin
               sc -= longint'(tc);
               ss -= longint'(ts);
            end else begin
               sc += longint'(tc);
               ss += longint'(ts);
            end
         end
         twiddle_re[k] = upper ? quantize_twiddle(-sc) : quantize_twiddle(sc);
         twiddle_im[k] = quantize_twiddle(-ss);
      end
   endtask

   function automatic longint wrap_word(longint v);
      logic signed [WORD_BITS-1:0] w;
      w = v[WORD_BITS-1:0];
      return longint'(w);
   endfunction

   task automatic transform_in_place();
      int rev, half, step;
      longint tmp, wr, wi, pr, pim, ar, ai;
      for (int i = 0; i < POINTS; i++) begin
         rev = 0;
         for (int b = 0; b < LOG_POINTS; b++) rev = (rev << 1) | ((i >> b) & 1);
         if (i < rev) begin
            tmp = spectrum_re[i]; spectrum_re[i] = spectrum_re[rev]; spectrum_re[rev] = tmp;
            tmp = spectrum_im[i]; spectrum_im[i] = spectrum_im[rev]; spectrum_im[rev] = tmp;
         end
      end
      for (int len = 2; len <= POINTS; len <<= 1) begin
         half = len / 2;
         step = POINTS / len;
         for (int i = 0; i < POINTS; i += len) begin
            for (int k = 0; k < half; k++) begin
               wr = twiddle_re[(k * step) & (POINTS / 2 - 1)];
               wi = twiddle_im[(k * step) & (POINTS / 2 - 1)];
               pr = (spectrum_re[i+k+half] * wr - spectrum_im[i+k+half] * wi
                     + (64'sd1 << (TW_FRAC - 1))) >>> TW_FRAC;
               pim = (spectrum_re[i+k+half] * wi + spectrum_im[i+k+half] * wr
                      + (64'sd1 << (TW_FRAC - 1))) >>> TW_FRAC;
               ar = spectrum_re[i+k];
               ai = spectrum_im[i+k];
               spectrum_re[i+k] = wrap_word(ar + pr);
               spectrum_im[i+k] = wrap_word(ai + pim);
               spectrum_re[i+k+half] = wrap_word(ar - pr);
               spectrum_im[i+k+half] = wrap_word(ai - pim);
            end
         end
      end
   endtask

   task automatic predict_request(fft_request_type rq);
      fft_response_type rs;
      case (rq.mode)
         MODE_LOAD: begin
            spectrum_re[rq.index] = longint'(rq.sample_real);
            spectrum_im[rq.index] = longint'(rq.sample_imag);
            load_count++;
         end
         MODE_RUN: begin
            transform_in_place();
            rs.kind = KIND_DONE;
            rs.bin_index = '0;
            rs.bin_real = '0;
            rs.bin_imag = '0;
            expected_bins.insert(expected_bins.size(), rs);
            run_count++;
         end
         MODE_READ: begin
            rs.kind = KIND_BIN;
            rs.bin_index = rq.index;
            rs.bin_real = spectrum_re[rq.index][WORD_BITS-1:0];
            rs.bin_imag = spectrum_im[rq.index][WORD_BITS-1:0];
            expected_bins.insert(expected_bins.size(), rs);
            read_count++;
         end
         default: ;
      endcase
   endtask

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(15))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_request(logic [MODE_BITS-1:0] mode, int index);
      fft_request_type rq;
      rq.mode = mode;
      rq.index = INDEX_BITS'(index);
      rq.sample_real = random_sample();
      rq.sample_imag = random_sample();
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_request(active_request);
         if (!start || !busy) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
               active_request = pending_requests.pop_front();
               req_mode <= active_request.mode;
               req_index <= active_request.index;
               req_sample_real <= active_request.sample_real;
               req_sample_imag <= active_request.sample_imag;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // response monitor and watchdog
   always @(posedge clock) begin
      fft_response_type exp_rs;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_bins.size() == 0) begin
               $error("unexpected response kind=%0d index=%0d", rsp_kind, rsp_bin_index);
               error_count++;
            end else begin
               exp_rs = expected_bins.pop_front();
               if (rsp_kind !== exp_rs.kind) begin
                  $error("kind: expected %0d, got %0d", exp_rs.kind, rsp_kind);
                  error_count++;
               end
               if (rsp_bin_index !== exp_rs.bin_index) begin
                  $error("bin_index: expected %0d, got %0d", exp_rs.bin_index, rsp_bin_index);
                  error_count++;
               end
               if (rsp_bin_real !== exp_rs.bin_real) begin
                  $error("bin_real: expected %0d, got %0d", exp_rs.bin_real, rsp_bin_real);
                  error_count++;
               end
               if (rsp_bin_imag !== exp_rs.bin_imag) begin
                  $error("bin_imag: expected %0d, got %0d", exp_rs.bin_imag, rsp_bin_imag);
                  error_count++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
            $display("tb_radix2_fft_engine: errors");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_requests.size() > 0 || start || expected_bins.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      int sel;
      build_twiddles();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fill the whole store before any run; extremes fall on the corners
      for (int i = 0; i < POINTS; i++) queue_request(MODE_LOAD, i);
      pending_requests[0].sample_real = 16'sh7fff;
      pending_requests[0].sample_imag = 16'sh8000;
      pending_requests[POINTS-1].sample_real = 16'sh8000;
      pending_requests[POINTS-1].sample_imag = 16'sh7fff;
      queue_request(MODE_READ, 0);
      queue_request(MODE_READ, POINTS - 1);
      queue_request(MODE_UNUSED, 5);
      queue_request(MODE_READ, 5);
      queue_request(MODE_RUN, 0);
      queue_request(MODE_READ, 0);
      queue_request(MODE_READ, 1);
      queue_request(MODE_READ, POINTS / 2);
      queue_request(MODE_READ, POINTS - 1);
      // transform again on top of the previous result
      queue_request(MODE_RUN, 0);
      queue_request(MODE_READ, 0);
      queue_request(MODE_READ, POINTS - 1);
      queue_request(MODE_LOAD, 7);
      queue_request(MODE_READ, 7);
      queue_request(MODE_UNUSED, POINTS - 1);
      drain();

      foreach (idle_pct_list[p]) begin
         idle_pct = idle_pct_list[p];
         sel = $urandom_range(359);
         for (int n = 0; n < 360; n++) begin
            if (n == sel) queue_request(MODE_RUN, $urandom_range(POINTS - 1));
            else case ($urandom_range(99))
               0, 1: queue_request(MODE_UNUSED, $urandom_range(POINTS - 1));
               default: begin
                  if ($urandom_range(99) < 65) queue_request(MODE_LOAD, $urandom_range(POINTS - 1));
                  else queue_request(MODE_READ, $urandom_range(POINTS - 1));
               end
            endcase
         end
         drain();
      end

      $display("covered %0d loads, %0d transforms, %0d bin reads", load_count, run_count,
               read_count);
      if (error_count == 0) $display("tb_radix2_fft_engine: clean");
      else $display("tb_radix2_fft_engine: errors");
      $finish;
   end

endmodule

FILE: files.f
src/r2fft_pkg.sv
src/r2fft_bfly.sv
src/radix2_fft_engine.sv
verif/tb_radix2_fft_engine.sv
